FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked checks on clk_i with rst_ni low masking them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge out of reset
`define PFE_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define PFE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: design/pfe_pkg.sv
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared constants, codes and helpers of the postfix evaluator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pfe_pkg;

  localparam int unsigned DEF_STACK_DEPTH   = 32;
  localparam int unsigned DEF_VALUE_WIDTH   = 64;
  localparam int unsigned DEF_FRACTION_BITS = 32;

  localparam int unsigned DATA_W         = 64;
  localparam int unsigned CHAR_W         = 8;
  localparam int unsigned STATUS_W       = 3;
  localparam int unsigned FDIG_W         = 5;
  localparam int unsigned FRAC_DIGIT_CAP = 19;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_FEW   = 3'd1,
    ST_DIV0  = 3'd2,
    ST_DEPTH = 3'd3,
    ST_FULL  = 3'd4,
    ST_OVF   = 3'd5
  } status_e;

  function automatic logic [DATA_W-1:0] mag_of(input logic [DATA_W-1:0] v);
    mag_of = v[DATA_W-1] ? (~v + DATA_W'(1)) : v;
  endfunction

  // {in range, two's complement value}
  function automatic logic [DATA_W:0] make_value(input logic [DATA_W-1:0] mag,
                                                 input logic              neg,
                                                 input int unsigned       vw);
    logic [DATA_W-1:0] lim;
    logic              ok;
    lim = DATA_W'(1) << (vw - 1);
    ok  = neg ? (mag <= lim) : (mag < lim);
    make_value = {ok, neg ? (~mag + DATA_W'(1)) : mag};
  endfunction

  function automatic logic [DATA_W-1:0] pow10(input logic [FDIG_W-1:0] n);
    case (n)
      5'd0:    pow10 = 64'd1;
      5'd1:    pow10 = 64'd10;
      5'd2:    pow10 = 64'd100;
      5'd3:    pow10 = 64'd1000;
      5'd4:    pow10 = 64'd10000;
      5'd5:    pow10 = 64'd100000;
      5'd6:    pow10 = 64'd1000000;
      5'd7:    pow10 = 64'd10000000;
      5'd8:    pow10 = 64'd100000000;
      5'd9:    pow10 = 64'd1000000000;
      5'd10:   pow10 = 64'd10000000000;
      5'd11:   pow10 = 64'd100000000000;
      5'd12:   pow10 = 64'd1000000000000;
      5'd13:   pow10 = 64'd10000000000000;
      5'd14:   pow10 = 64'd100000000000000;
      5'd15:   pow10 = 64'd1000000000000000;
      5'd16:   pow10 = 64'd10000000000000000;
      5'd17:   pow10 = 64'd100000000000000000;
      5'd18:   pow10 = 64'd1000000000000000000;
      default: pow10 = 64'd10000000000000000000;
    endcase
  endfunction

endpackage

FILE: design/pfe_ram.sv
// ----------------------------------------------------------------------------
// pfe_ram
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfe_ram #(
  parameter int unsigned WIDTH = pfe_pkg::DEF_VALUE_WIDTH,
  parameter int unsigned DEPTH = pfe_pkg::DEF_STACK_DEPTH
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/pfe_div.sv
// ----------------------------------------------------------------------------
// pfe_div
// Restoring divider, one quotient bit a cycle, rounded to nearest:
// round(num * 2^FRACTION_BITS / den), with overflow past the value range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfe_div #(
  parameter int unsigned VALUE_WIDTH   = pfe_pkg::DEF_VALUE_WIDTH,
  parameter int unsigned FRACTION_BITS = pfe_pkg::DEF_FRACTION_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [pfe_pkg::DATA_W-1:0] num_i,
  input  logic [pfe_pkg::DATA_W-1:0] den_i,
  output logic                      busy_o,
  output logic                      done_o,
  output logic                      ok_o,
  output logic [pfe_pkg::DATA_W-1:0] mag_o
);
  import pfe_pkg::*;

  localparam int unsigned Steps = DATA_W + FRACTION_BITS;
  localparam int unsigned CntW  = $clog2(Steps + 1);
  localparam int unsigned QW    = VALUE_WIDTH + 1;
  localparam logic [QW-1:0] QLim = QW'(1) << (VALUE_WIDTH - 1);

  logic              busy_q, busy_d, round_q, round_d, done_q, done_d, ovf_q, ovf_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [DATA_W-1:0] num_q, num_d, den_q, den_d, rem_q, rem_d;
  logic [QW-1:0]     quo_q, quo_d, quo_sh, quo_inc;
  logic [DATA_W:0]   rem_sh, rem_sub;
  logic              qbit;

  always_comb begin
    rem_sh  = {rem_q, num_q[DATA_W-1]};
    rem_sub = rem_sh - {1'b0, den_q};
    qbit    = rem_sh >= {1'b0, den_q};
    quo_sh  = {quo_q[QW-2:0], qbit};
    quo_inc = quo_q + QW'(1);

    busy_d  = busy_q;
    round_d = round_q;
    done_d  = 1'b0;
    ovf_d   = ovf_q;
    cnt_d   = cnt_q;
    num_d   = num_q;
    den_d   = den_q;
    rem_d   = rem_q;
    quo_d   = quo_q;

    if (start_i) begin
      busy_d  = 1'b1;
      round_d = 1'b0;
      ovf_d   = 1'b0;
      cnt_d   = '0;
      num_d   = num_i;
      den_d   = den_i;
      rem_d   = '0;
      quo_d   = '0;
    end else if (busy_q && !round_q) begin
      num_d = num_q << 1;
      rem_d = qbit ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
      if (!ovf_q) begin
        quo_d = quo_sh;
        ovf_d = quo_sh > QLim;
      end
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(Steps - 1)) begin
        round_d = 1'b1;
      end
    end else if (busy_q) begin
      busy_d  = 1'b0;
      round_d = 1'b0;
      done_d  = 1'b1;
      if (!ovf_q && ({rem_q, 1'b0} >= {1'b0, den_q})) begin
        quo_d = quo_inc;
        ovf_d = quo_inc > QLim;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      round_q <= 1'b0;
      done_q  <= 1'b0;
      ovf_q   <= 1'b0;
      cnt_q   <= '0;
    end else begin
      busy_q  <= busy_d;
      round_q <= round_d;
      done_q  <= done_d;
      ovf_q   <= ovf_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign ok_o   = !ovf_q;
  assign mag_o  = DATA_W'(quo_q);

endmodule

FILE: design/pfe_mul.sv
// ----------------------------------------------------------------------------
// pfe_mul
// Unsigned 64x64 multiplier, one 32x32 partial product a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfe_mul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [pfe_pkg::DATA_W-1:0]   x_i,
  input  logic [pfe_pkg::DATA_W-1:0]   y_i,
  output logic                        busy_o,
  output logic                        done_o,
  output logic [2*pfe_pkg::DATA_W-1:0] prod_o
);
  import pfe_pkg::*;

  localparam int unsigned HW = DATA_W / 2;
  localparam int unsigned PW = 2 * DATA_W;

  logic              busy_q, busy_d, done_q, done_d;
  logic [1:0]        step_q, step_d;
  logic [DATA_W-1:0] x_q, x_d, y_q, y_d;
  logic [PW-1:0]     acc_q, acc_d, pp_w;
  logic [HW-1:0]     xh, yh;
  logic [DATA_W-1:0] pp;
  logic [7:0]        sh;

  always_comb begin
    xh   = step_q[0] ? x_q[DATA_W-1:HW] : x_q[HW-1:0];
    yh   = step_q[1] ? y_q[DATA_W-1:HW] : y_q[HW-1:0];
    pp   = xh * yh;
    sh   = (8'(step_q[0]) + 8'(step_q[1])) * 8'(HW);
    pp_w = PW'(pp) << sh;

    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    x_d    = x_q;
    y_d    = y_q;
    acc_d  = acc_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      x_d    = x_i;
      y_d    = y_i;
      acc_d  = '0;
    end else if (busy_q) begin
      acc_d  = acc_q + pp_w;
      step_d = step_q + 2'd1;
      if (step_q == 2'd3) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    acc_q <= acc_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

FILE: design/postfix_expression_evaluator.sv
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// Postfix evaluator on a RAM value stack, signed fixed-point values.
// ----------------------------------------------------------------------------
// Bytes of an expression stream in one word at a time; a zero byte ends it
// and yields one result word (value in tdata, status in tuser). Digits,
// points, spaces and operator bytes that start or glue to a token are
// absorbed in the idle state. A lone + or - reads two stack entries and
// writes one back, a lone * runs four 32x32 partial products, and a lone /
// and the end of a number run the bit-serial divider. After any pending
// operator or number, the end byte reads the stack bottom and emits the
// result word; with an error already set it emits at once.
// Input is taken while a result waits.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module postfix_expression_evaluator #(
  parameter int unsigned STACK_DEPTH   = pfe_pkg::DEF_STACK_DEPTH,
  parameter int unsigned VALUE_WIDTH   = pfe_pkg::DEF_VALUE_WIDTH,
  parameter int unsigned FRACTION_BITS = pfe_pkg::DEF_FRACTION_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [pfe_pkg::CHAR_W-1:0]    s_axis_tdata,  // [7:0] character
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [pfe_pkg::DATA_W-1:0]    m_axis_tdata,  // [63:0] value
  output logic [pfe_pkg::STATUS_W-1:0]  m_axis_tuser   // [2:0] status
);
  import pfe_pkg::*;

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned DW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned PW = 2 * DATA_W;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_APPLY = 11'b000_0000_0010,
    S_RDA   = 11'b000_0000_0100,
    S_EXEC  = 11'b000_0000_1000,
    S_MULW  = 11'b000_0001_0000,
    S_DIVW  = 11'b000_0010_0000,
    S_FIN   = 11'b000_0100_0000,
    S_FWAIT = 11'b000_1000_0000,
    S_RDOUT = 11'b001_0000_0000,
    S_EMIT  = 11'b010_0000_0000,
    S_SPARE = 11'b100_0000_0000
  } state_e;

  state_e            state_q, state_d, after;
  logic [DW-1:0]     depth_q, depth_d, depth_m1, depth_m2;
  logic [DATA_W-1:0] mant_q, mant_d;
  logic [FDIG_W-1:0] fd_q, fd_d;
  logic              tin_q, tin_d, tneg_q, tneg_d, tpt_q, tpt_d, tstop_q, tstop_d;
  op_e               pend_q, pend_d, op_q, op_d, chr_op;
  status_e           err_q, err_d, out_status_q, out_status_d;
  logic              end_q, end_d, neg_q, neg_d;
  logic [DATA_W-1:0] b_q, b_d;
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_value_q, out_value_d;

  logic [CHAR_W-1:0] chr;
  logic              accept;

  // token feed
  logic [DATA_W-1:0]   f_m, n_m;
  logic [FDIG_W-1:0]   f_fd, n_fd;
  logic                f_pt, f_stop, f_neg, n_pt, n_stop, n_ovf, is_digit, fits;
  logic [3:0]          dval;
  logic [DATA_W+3:0]   m10;

  // arithmetic
  logic [DATA_W-1:0] a_ext, bb, sum;
  logic              as_ovf, m_rb, m_hi, m_ovf;
  logic [DATA_W:0]   as_mv, m_mv, d_mv, f_mv;
  logic [PW:0]       pext;
  logic [DATA_W-1:0] m_mag;

  // stack RAM and units
  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [VALUE_WIDTH-1:0] ram_wdata, ram_rdata;
  logic                 div_start, div_busy, div_done, div_ok;
  logic [DATA_W-1:0]    div_num, div_den, div_mag;
  logic                 mul_start, mul_busy, mul_done;
  logic [PW-1:0]        mul_prod;

  pfe_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  pfe_div #(
    .VALUE_WIDTH   (VALUE_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .ok_o    (div_ok),
    .mag_o   (div_mag)
  );

  pfe_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .x_i     (mag_of(a_ext)),
    .y_i     (mag_of(b_q)),
    .busy_o  (mul_busy),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  assign chr           = s_axis_tdata;
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    unique case (chr)
      CH_PLUS:  chr_op = OP_ADD;
      CH_MINUS: chr_op = OP_SUB;
      CH_STAR:  chr_op = OP_MUL;
      CH_SLASH: chr_op = OP_DIV;
      default:  chr_op = OP_NONE;
    endcase
  end

  // one byte into the number being parsed
  always_comb begin
    if (pend_q != OP_NONE) begin
      f_m    = '0;
      f_fd   = '0;
      f_pt   = 1'b0;
      f_stop = (pend_q == OP_MUL) || (pend_q == OP_DIV);
      f_neg  = (pend_q == OP_SUB);
    end else if (tin_q) begin
      f_m    = mant_q;
      f_fd   = fd_q;
      f_pt   = tpt_q;
      f_stop = tstop_q;
      f_neg  = tneg_q;
    end else begin
      f_m    = '0;
      f_fd   = '0;
      f_pt   = 1'b0;
      f_stop = 1'b0;
      f_neg  = 1'b0;
    end
    is_digit = (chr >= CH_ZERO) && (chr <= CH_NINE);
    dval     = 4'(chr - CH_ZERO);
    m10      = ({4'b0, f_m} << 3) + ({4'b0, f_m} << 1) + (DATA_W + 4)'(dval);
    fits     = (m10[DATA_W+3:DATA_W] == 4'd0);
    n_m      = f_m;
    n_fd     = f_fd;
    n_pt     = f_pt;
    n_stop   = f_stop;
    n_ovf    = 1'b0;
    if (!f_stop) begin
      if (is_digit) begin
        if (f_pt) begin
          if (fits && (f_fd < FDIG_W'(FRAC_DIGIT_CAP))) begin
            n_m  = m10[DATA_W-1:0];
            n_fd = f_fd + FDIG_W'(1);
          end
        end else if (fits) begin
          n_m = m10[DATA_W-1:0];
        end else begin
          n_ovf = 1'b1;
        end
      end else if ((chr == CH_POINT) && !f_pt) begin
        n_pt = 1'b1;
      end else begin
        n_stop = 1'b1;
      end
    end
  end

  always_comb begin
    a_ext  = DATA_W'($signed(ram_rdata));
    bb     = (op_q == OP_SUB) ? ~b_q : b_q;
    sum    = a_ext + bb + DATA_W'(op_q == OP_SUB);
    as_ovf = (~(a_ext[DATA_W-1] ^ bb[DATA_W-1])) & (a_ext[DATA_W-1] ^ sum[DATA_W-1]);
    as_mv  = make_value(mag_of(sum), sum[DATA_W-1], VALUE_WIDTH);

    pext   = {mul_prod, 1'b0};
    m_rb   = pext[FRACTION_BITS];
    m_mag  = pext[FRACTION_BITS+DATA_W -: DATA_W];
    m_hi   = |(pext >> (FRACTION_BITS + DATA_W + 1));
    m_ovf  = m_hi || (m_rb && (&m_mag));
    m_mv   = make_value(m_mag + DATA_W'(m_rb), neg_q, VALUE_WIDTH);

    d_mv   = make_value(div_mag, neg_q, VALUE_WIDTH);
    f_mv   = make_value(div_mag, tneg_q, VALUE_WIDTH);
  end

  assign depth_m1 = depth_q - DW'(1);
  assign depth_m2 = depth_q - DW'(2);

  always_comb begin
    state_d      = state_q;
    depth_d      = depth_q;
    mant_d       = mant_q;
    fd_d         = fd_q;
    tin_d        = tin_q;
    tneg_d       = tneg_q;
    tpt_d        = tpt_q;
    tstop_d      = tstop_q;
    pend_d       = pend_q;
    op_d         = op_q;
    err_d        = err_q;
    end_d        = end_q;
    neg_d        = neg_q;
    b_d          = b_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = depth_m2[AW-1:0];
    ram_raddr    = depth_m1[AW-1:0];
    ram_wdata    = '0;
    div_start    = 1'b0;
    div_num      = mant_q;
    div_den      = pow10(fd_q);
    mul_start    = 1'b0;
    after        = end_q ? S_RDOUT : S_IDLE;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (chr == CH_NUL) begin
            end_d = 1'b1;
            if (err_q != ST_OK) begin
              state_d = S_EMIT;
            end else if (pend_q != OP_NONE) begin
              op_d    = pend_q;
              pend_d  = OP_NONE;
              state_d = S_APPLY;
            end else if (tin_q) begin
              state_d = S_FIN;
            end else begin
              state_d = S_RDOUT;
            end
          end else if (err_q == ST_OK) begin
            if ((pend_q != OP_NONE) && (chr == CH_SPACE)) begin
              op_d    = pend_q;
              pend_d  = OP_NONE;
              state_d = S_APPLY;
            end else if (tin_q && (chr == CH_SPACE)) begin
              state_d = S_FIN;
            end else if ((pend_q == OP_NONE) && !tin_q && (chr == CH_SPACE)) begin
              state_d = S_IDLE;
            end else if ((pend_q == OP_NONE) && !tin_q && (chr_op != OP_NONE)) begin
              pend_d = chr_op;
            end else begin
              pend_d  = OP_NONE;
              tin_d   = 1'b1;
              tneg_d  = f_neg;
              mant_d  = n_m;
              fd_d    = n_fd;
              tpt_d   = n_pt;
              tstop_d = n_stop;
              if (n_ovf) begin
                err_d = ST_OVF;
              end
            end
          end
        end
      end
      S_APPLY: begin
        if (depth_q < DW'(2)) begin
          err_d   = ST_FEW;
          state_d = after;
        end else begin
          ram_re  = 1'b1;
          state_d = S_RDA;
        end
      end
      S_RDA: begin
        b_d       = DATA_W'($signed(ram_rdata));
        ram_re    = 1'b1;
        ram_raddr = depth_m2[AW-1:0];
        state_d   = S_EXEC;
      end
      S_EXEC: begin
        neg_d = a_ext[DATA_W-1] ^ b_q[DATA_W-1];
        case (op_q) inside
          OP_ADD, OP_SUB: begin
            if (as_ovf || !as_mv[DATA_W]) begin
              err_d = ST_OVF;
            end else begin
              ram_we    = 1'b1;
              ram_wdata = as_mv[VALUE_WIDTH-1:0];
              depth_d   = depth_m1;
            end
            state_d = after;
          end
          OP_MUL: begin
            mul_start = 1'b1;
            state_d   = S_MULW;
          end
          OP_DIV: begin
            if (b_q == '0) begin
              err_d   = ST_DIV0;
              state_d = after;
            end else begin
              div_start = 1'b1;
              div_num   = mag_of(a_ext);
              div_den   = mag_of(b_q);
              state_d   = S_DIVW;
            end
          end
          default: state_d = after;
        endcase
      end
      S_MULW: begin
        if (mul_done) begin
          if (m_ovf || !m_mv[DATA_W]) begin
            err_d = ST_OVF;
          end else begin
            ram_we    = 1'b1;
            ram_wdata = m_mv[VALUE_WIDTH-1:0];
            depth_d   = depth_m1;
          end
          state_d = after;
        end
      end
      S_DIVW: begin
        if (div_done) begin
          if (!div_ok || !d_mv[DATA_W]) begin
            err_d = ST_OVF;
          end else begin
            ram_we    = 1'b1;
            ram_wdata = d_mv[VALUE_WIDTH-1:0];
            depth_d   = depth_m1;
          end
          state_d = after;
        end
      end
      S_FIN: begin
        div_start = 1'b1;
        state_d   = S_FWAIT;
      end
      S_FWAIT: begin
        if (div_done) begin
          if (!div_ok || !f_mv[DATA_W]) begin
            err_d = ST_OVF;
          end else if (depth_q >= DW'(STACK_DEPTH)) begin
            err_d = ST_FULL;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = depth_q[AW-1:0];
            ram_wdata = f_mv[VALUE_WIDTH-1:0];
            depth_d   = depth_q + DW'(1);
          end
          mant_d  = '0;
          fd_d    = '0;
          tin_d   = 1'b0;
          tneg_d  = 1'b0;
          tpt_d   = 1'b0;
          tstop_d = 1'b0;
          state_d = after;
        end
      end
      S_RDOUT: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
        if ((err_q == ST_OK) && (depth_q != DW'(1))) begin
          err_d = ST_DEPTH;
        end
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d  = 1'b1;
          out_value_d  = (err_q == ST_OK) ? DATA_W'($signed(ram_rdata)) : '0;
          out_status_d = err_q;
          depth_d      = '0;
          mant_d       = '0;
          fd_d         = '0;
          tin_d        = 1'b0;
          tneg_d       = 1'b0;
          tpt_d        = 1'b0;
          tstop_d      = 1'b0;
          pend_d       = OP_NONE;
          err_d        = ST_OK;
          end_d        = 1'b0;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      depth_q      <= '0;
      mant_q       <= '0;
      fd_q         <= '0;
      tin_q        <= 1'b0;
      tneg_q       <= 1'b0;
      tpt_q        <= 1'b0;
      tstop_q      <= 1'b0;
      pend_q       <= OP_NONE;
      op_q         <= OP_NONE;
      err_q        <= ST_OK;
      end_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_OK;
    end else begin
      state_q      <= state_d;
      depth_q      <= depth_d;
      mant_q       <= mant_d;
      fd_q         <= fd_d;
      tin_q        <= tin_d;
      tneg_q       <= tneg_d;
      tpt_q        <= tpt_d;
      tstop_q      <= tstop_d;
      pend_q       <= pend_d;
      op_q         <= op_d;
      err_q        <= err_d;
      end_q        <= end_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q       <= neg_d;
    b_q         <= b_d;
    out_value_q <= out_value_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_value_q;
  assign m_axis_tuser  = out_status_q;

  `PFE_ASSERT(a_depth_bound, depth_q <= DW'(STACK_DEPTH), "stack depth beyond capacity")
  `PFE_ASSERT_IMPL(a_err_value_zero, m_axis_tvalid && (m_axis_tuser != ST_OK),
                   m_axis_tdata == '0, "error result carries a nonzero value")
  `PFE_ASSERT_IMPL(a_ready_units_idle, s_axis_tready, !div_busy && !mul_busy,
                   "input taken while an arithmetic unit is busy")

endmodule

FILE: tb/tb_postfix_expression_evaluator.sv
// ----------------------------------------------------------------------------
// tb_postfix_expression_evaluator
// Self-checking bench for the postfix evaluator: expressions are streamed in
// one word per character, and each result word is checked against a
// Q31.32 stack machine kept in the scoreboard.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_postfix_expression_evaluator;
  import pfe_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 3000000;
  localparam int unsigned N_STACK      = 32;

  class expr_scoreboard;
    logic [63:0] stk [N_STACK];
    int unsigned depth;
    logic [63:0] mant;
    int unsigned fdig;
    bit          in_tok, neg, pt, stop;
    op_e         pend;
    status_e     err;
    logic [63:0] exp_value [$];
    status_e     exp_status [$];
    int unsigned mismatches, results;
    int unsigned per_status [6];

    function new();
      clear();
    endfunction

    function void clear();
      depth = 0;
      mant = '0;
      fdig = 0;
      {in_tok, neg, pt, stop} = '0;
      pend = OP_NONE;
      err = ST_OK;
    endfunction

    function logic [63:0] magnitude(logic [63:0] v);
      return v[63] ? ~v + 64'd1 : v;
    endfunction

    function bit to_signed(logic [63:0] m, bit n, output logic [63:0] r);
      r = n ? ~m + 64'd1 : m;
      return n ? (m <= 64'h8000_0000_0000_0000) : (m <= 64'h7FFF_FFFF_FFFF_FFFF);
    endfunction

    // round(num * 2^32 / den), bit-serial with a 64-bit remainder
    function bit quotient(logic [63:0] num, logic [63:0] den, output logic [63:0] q);
      logic [63:0] r;
      bit carry, qb, ovf;
      q = '0;
      r = '0;
      ovf = 0;
      for (int i = 0; i < 96; i++) begin
        carry = r[63];
        r = {r[62:0], (i < 64) ? num[63-i] : 1'b0};
        qb = 0;
        if (carry || r >= den) begin
          r = r - den;
          qb = 1;
        end
        if (!ovf) begin
          q = {q[62:0], qb};
          if (q > 64'h8000_0000_0000_0000) ovf = 1;
        end
      end
      if (!ovf && (r[63] || {r[62:0], 1'b0} >= den)) begin
        q = q + 64'd1;
        if (q > 64'h8000_0000_0000_0000) ovf = 1;
      end
      return !ovf;
    endfunction

    function bit product(logic [63:0] a, logic [63:0] b, output logic [63:0] r);
      logic [127:0] p;
      logic [63:0]  m;
      p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
      if (p[127:96] != 0) return 0;
      m = p[95:32];
      if (p[31]) begin
        if (m == '1) return 0;
        m = m + 64'd1;
      end
      return to_signed(m, a[63] ^ b[63], r);
    endfunction

    function void flag(status_e s);
      if (err == ST_OK) err = s;
    endfunction

    function void push(logic [63:0] v);
      if (depth >= N_STACK) begin
        flag(ST_FULL);
        return;
      end
      stk[depth] = v;
      depth++;
    endfunction

    function void apply(op_e op);
      logic [63:0] a, b, r, s, m;
      bit ok;
      if (depth < 2) begin
        flag(ST_FEW);
        return;
      end
      b = stk[depth-1];
      a = stk[depth-2];
      if (op == OP_ADD || op == OP_SUB) begin
        s = (op == OP_ADD) ? a + b : a - b;
        m = (op == OP_ADD) ? b : ~b;
        if ((~(a ^ m) & (a ^ s)) >> 63) ok = 0;
        else ok = to_signed(magnitude(s), s[63], r);
      end else if (op == OP_MUL) begin
        ok = product(a, b, r);
      end else begin
        if (b == 0) begin
          flag(ST_DIV0);
          return;
        end
        ok = quotient(magnitude(a), magnitude(b), m);
        if (ok) ok = to_signed(m, a[63] ^ b[63], r);
      end
      if (!ok) begin
        flag(ST_OVF);
        return;
      end
      stk[depth-2] = r;
      depth--;
    endfunction

    function void end_number();
      logic [63:0] den, m, v;
      den = 64'd1;
      for (int i = 0; i < fdig && i < FRAC_DIGIT_CAP; i++) den = den * 64'd10;
      if (!quotient(mant, den, m) || !to_signed(m, neg, v)) flag(ST_OVF);
      else push(v);
      mant = '0;
      fdig = 0;
      {in_tok, neg, pt, stop} = '0;
    endfunction

    function void digit_or_stop(logic [7:0] c);
      logic [63:0] d;
      bit fits;
      if (stop) return;
      if (c >= CH_ZERO && c <= CH_NINE) begin
        d = 64'(c - CH_ZERO);
        fits = mant <= ('1 - d) / 64'd10;
        if (pt) begin
          if (fits && fdig < FRAC_DIGIT_CAP) begin
            mant = mant * 64'd10 + d;
            fdig++;
          end
        end else if (fits) begin
          mant = mant * 64'd10 + d;
        end else begin
          flag(ST_OVF);
        end
      end else if (c == CH_POINT && !pt) begin
        pt = 1;
      end else begin
        stop = 1;
      end
    endfunction

    function op_e op_of(logic [7:0] c);
      case (c)
        CH_PLUS:  return OP_ADD;
        CH_MINUS: return OP_SUB;
        CH_STAR:  return OP_MUL;
        CH_SLASH: return OP_DIV;
        default:  return OP_NONE;
      endcase
    endfunction

    function void start_number(logic [7:0] c);
      mant = '0;
      fdig = 0;
      {in_tok, neg, pt, stop} = 4'b1000;
      digit_or_stop(c);
    endfunction

    function void note_char(logic [7:0] c);
      op_e op;
      if (c == CH_NUL) begin
        if (err == ST_OK) begin
          if (pend != OP_NONE) apply(pend);
          else if (in_tok) end_number();
        end
        if (err == ST_OK && depth != 1) err = ST_DEPTH;
        exp_value.push_back(err == ST_OK ? stk[0] : 64'd0);
        exp_status.push_back(err);
        clear();
        return;
      end
      if (err != ST_OK) return;
      if (pend != OP_NONE) begin
        op = pend;
        pend = OP_NONE;
        if (c == CH_SPACE) begin
          apply(op);
          return;
        end
        mant = '0;
        fdig = 0;
        {in_tok, neg, pt, stop} = 4'b1000;
        if (op == OP_SUB) neg = 1;
        else if (op == OP_MUL || op == OP_DIV) stop = 1;
        digit_or_stop(c);
        return;
      end
      if (in_tok) begin
        if (c == CH_SPACE) end_number();
        else digit_or_stop(c);
        return;
      end
      if (c == CH_SPACE) return;
      if (op_of(c) != OP_NONE) begin
        pend = op_of(c);
        return;
      end
      start_number(c);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      mismatches++;
      $display("MISMATCH result %0d %s: got %h want %h", results, what, got, want);
    endtask

    task check_word(logic [63:0] value, logic [2:0] status);
      if (exp_status.size() == 0) begin
        report("unexpected word", value, 0);
        return;
      end
      if (status !== exp_status[0]) report("status", status, exp_status[0]);
      if (value !== exp_value[0]) report("value", value, exp_value[0]);
      if (exp_status[0] <= ST_OVF) per_status[exp_status[0]]++;
      void'(exp_status.pop_front());
      void'(exp_value.pop_front());
      results++;
    endtask
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [63:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  expr_scoreboard sb = new();
  bit          idle_on = 1;
  bit          hold_req = 0;
  int unsigned hold_cnt = 0;
  int unsigned chars_sent = 0;
  longint unsigned cycles = 0;

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  postfix_expression_evaluator u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_postfix_expression_evaluator NOT OK");
      $finish;
    end
  end

  // receiver: long hold-off on request, else random stalls while idle_on is set
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready)
        sb.check_word(m_axis_tdata, m_axis_tuser);
      if (hold_req && hold_cnt == 0) begin
        hold_req = 0;
        hold_cnt = 600;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !(idle_on && $urandom_range(99) < 31);
      end
    end
  end

  task send_char(logic [7:0] c);
    while (idle_on && $urandom_range(99) < 31) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_char(c);
    chars_sent++;
  endtask

  task send_expr(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
    send_char(CH_NUL);
  endtask

  function string digits(int unsigned n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(byte'(CH_ZERO + $urandom_range(9)))};
    return s;
  endfunction

  function string rand_number();
    string s;
    int unsigned k;
    k = $urandom_range(99);
    s = "";
    if (k < 25) s = "-";
    else if (k < 30) s = "+";
    s = {s, digits(($urandom_range(19) == 0) ? $urandom_range(10, 21) : $urandom_range(0, 4))};
    if ($urandom_range(2) == 0)
      s = {s, ".", digits(($urandom_range(14) == 0) ? 22 : $urandom_range(0, 6))};
    if ($urandom_range(19) == 0) s = {s, ($urandom_range(1) ? ".5" : "x9")};
    return s;
  endfunction

  function string rand_expr();
    string s, ops;
    int unsigned n, lvl;
    ops = "+-*/";
    s = "";
    lvl = 0;
    n = $urandom_range(1, 6);
    while (n > 0 || lvl > 1) begin
      if (lvl >= 2 && (n == 0 || $urandom_range(2) == 0)) begin
        s = {s, string'(ops[$urandom_range(3)]), " "};
        lvl--;
      end else begin
        s = {s, rand_number(), " "};
        lvl++;
        n--;
      end
    end
    if ($urandom_range(1)) s = s.substr(0, s.len() - 2);
    if ($urandom_range(14) == 0) s = {s, " +"};
    return s;
  endfunction

  task send_noise();
    int unsigned n;
    n = $urandom_range(1, 12);
    repeat (n) send_char($urandom_range(1, 255));
    send_char(CH_NUL);
  endtask

  initial begin
    string deep;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_expr("3 4 +");
    send_expr("10 4.5 -");
    send_expr("2.5 -4 *");
    send_expr("1 3 /");
    send_expr("7 0 /");
    send_expr("+");
    send_expr("1 2");
    send_expr("");
    send_expr("-3.25");
    send_expr("+7");
    send_expr("*5");
    send_expr("/5 ");
    send_expr("1.2.3");
    send_expr("12ab 1 +");
    send_expr("99999999999999999999");
    send_expr("0.1234567890123456789012");
    send_expr("2147483647 1 +");
    send_expr("-2147483648");
    send_expr("2147483648");
    send_expr("65536 65536 *");
    send_expr("-1 -2147483648 *");
    send_expr("1 0.0000000001 /");
    send_expr("5 6- ");
    deep = "";
    repeat (33) deep = {deep, "1 "};
    send_expr(deep);
    deep = "";
    repeat (32) deep = {deep, "2 "};
    repeat (31) deep = {deep, "+ "};
    send_expr(deep);

    while (chars_sent < 1550) begin
      if (chars_sent > 500 && chars_sent < 800) idle_on = 0;
      else idle_on = 1;
      if (chars_sent > 900 && chars_sent < 920 && hold_cnt == 0) hold_req = 1;
      if ($urandom_range(9) < 8) send_expr(rand_expr());
      else send_noise();
    end
    s_axis_tvalid <= 1'b0;

    while (sb.exp_status.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);

    $display("%0d characters sent, %0d results checked", chars_sent, sb.results);
    $display("results by status ok/few/div0/depth/full/ovf: %0d %0d %0d %0d %0d %0d",
             sb.per_status[0], sb.per_status[1], sb.per_status[2],
             sb.per_status[3], sb.per_status[4], sb.per_status[5]);
    if (sb.mismatches == 0 && sb.exp_status.size() == 0)
      $display("tb_postfix_expression_evaluator OK");
    else
      $display("tb_postfix_expression_evaluator NOT OK");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/pfe_pkg.sv
design/pfe_ram.sv
design/pfe_div.sv
design/pfe_mul.sv
design/postfix_expression_evaluator.sv
tb/tb_postfix_expression_evaluator.sv
